// File: src/bdeq_pkg.sv
package bdeq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int CAP_W     = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_FRONT,
    ST_RD_REAR,
    ST_DONE
  } state_e;

  // Status handed from the controller to the result registers.
  typedef struct packed {
    logic ok;
    logic empty;
    logic full;
    logic capture_front;
    logic capture_rear;
  } res_ctl_t;

endpackage

// File: src/bounded_double_ended_queue.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+---------------------------
// command   | cmd_i, value_i                                     | start_i high, busy_o low
// result    | ok_o, front_value_o, rear_value_o, is_empty_o,     | done_o high for one cycle
//           | is_full_o                                          |
// config    | cfg_wdata_i                                        | cfg_we_i high
//
// Each command beat runs from acceptance to the next possible acceptance as follows:
// the accepting cycle updates the indices and writes the entry memory, then the single read
// port of the memory fetches the front and the rear entry in turn, and the result registers load.
// The result beat is shown in the cycle in which busy_o has dropped again, so a new
// command may be accepted while the result is on the ports.
// Reset clears the indices, the count and the control state and sets the capacity limit
// to 1024; the entry memory is not cleared and needs no clearing pass.
// The receiver cannot stall: done_o is a strobe and every result beat is taken.
module bounded_double_ended_queue #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [bdeq_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [bdeq_pkg::DATA_W-1:0] value_i,
  input  logic                               cfg_we_i,
  input  logic [bdeq_pkg::CAP_W-1:0]         cfg_wdata_i,
  output logic                               done_o,
  output logic                               ok_o,
  output logic signed [bdeq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [bdeq_pkg::DATA_W-1:0] rear_value_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bdeq_pkg::CAP_W-1:0]  cap_q;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  logic [bdeq_pkg::DATA_W-1:0] ram_rdata;
  bdeq_pkg::res_ctl_t          ctl;

  logic                        done_q;
  logic                        ok_q;
  logic                        empty_q;
  logic                        full_q;
  logic [bdeq_pkg::DATA_W-1:0] front_q;
  logic [bdeq_pkg::DATA_W-1:0] rear_q;

  // The user must write the capacity limit only while no command is in flight; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bdeq_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  bdeq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .cap_i      (cap_q),
    .busy_o     (busy_o),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_raddr_o(ram_raddr),
    .ctl_o      (ctl)
  );

  // The push value goes straight into the entry memory in the accepting cycle.
  bdeq_ram #(
    .WIDTH(bdeq_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(value_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // An empty deque reports all ones for both ends.
  always_ff @(posedge clk_i) begin
    if (ctl.capture_front) begin
      front_q <= ctl.empty ? '1 : ram_rdata;
    end
    if (ctl.capture_rear) begin
      rear_q  <= ctl.empty ? '1 : ram_rdata;
      ok_q    <= ctl.ok;
      empty_q <= ctl.empty;
      full_q  <= ctl.full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl.capture_rear;
    end
  end

  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign front_value_o = front_q;
  assign rear_value_o  = rear_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

endmodule

// File: src/bdeq_ram.sv
module bdeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bdeq_ctrl.sv
module bdeq_ctrl #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bdeq_pkg::CMD_W-1:0]   cmd_i,
  input  logic [bdeq_pkg::CAP_W-1:0]   cap_i,
  output logic                         busy_o,
  output logic                         ram_we_o,
  output logic [AW-1:0]                ram_waddr_o,
  output logic [AW-1:0]                ram_raddr_o,
  output bdeq_pkg::res_ctl_t           ctl_o
);

  localparam int SW = CW + 1;
  localparam int LW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);
  localparam logic [AW-1:0] LastIdx  = AW'(DEPTH - 1);

  bdeq_pkg::state_e state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic          ok_q, ok_d;
  logic          full;
  logic          accept;
  logic [AW-1:0] front_dec;

  // Index arithmetic modulo DEPTH; b never exceeds DEPTH where it matters.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign accept    = start_i && (state_q == bdeq_pkg::ST_IDLE);
  assign busy_o    = (state_q != bdeq_pkg::ST_IDLE);
  assign full      = (LW'(count_q) >= LW'(cap_i)) || (count_q == DepthCnt);
  assign front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    ok_d        = ok_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = front_dec;
    ram_raddr_o = front_q;
    unique case (state_q)
      bdeq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = bdeq_pkg::ST_RD_FRONT;
          ok_d    = 1'b0;
          unique case (cmd_i)
            bdeq_pkg::CMD_PUSH_FRONT: begin
              if (!full) begin
                front_d  = front_dec;
                count_d  = count_q + 1'b1;
                ram_we_o = 1'b1;
                ok_d     = 1'b1;
              end
            end
            bdeq_pkg::CMD_PUSH_REAR: begin
              ram_waddr_o = ring_add(front_q, count_q);
              if (!full) begin
                count_d  = count_q + 1'b1;
                ram_we_o = 1'b1;
                ok_d     = 1'b1;
              end
            end
            bdeq_pkg::CMD_POP_FRONT: begin
              if (count_q != '0) begin
                front_d = ring_add(front_q, CW'(1));
                count_d = count_q - 1'b1;
                ok_d    = 1'b1;
              end
            end
            bdeq_pkg::CMD_POP_REAR: begin
              if (count_q != '0) begin
                count_d = count_q - 1'b1;
                ok_d    = 1'b1;
              end
            end
            bdeq_pkg::CMD_PEEK: begin
              ok_d = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      bdeq_pkg::ST_RD_FRONT: begin
        ram_raddr_o = front_q;
        state_d     = bdeq_pkg::ST_RD_REAR;
      end
      bdeq_pkg::ST_RD_REAR: begin
        ram_raddr_o = (count_q == '0) ? front_q : ring_add(front_q, count_q - 1'b1);
        state_d     = bdeq_pkg::ST_DONE;
      end
      bdeq_pkg::ST_DONE: begin
        state_d = bdeq_pkg::ST_IDLE;
      end
      default: begin
        state_d = bdeq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdeq_pkg::ST_IDLE;
      front_q <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

  assign ctl_o.ok            = ok_q;
  assign ctl_o.empty         = (count_q == '0);
  assign ctl_o.full          = full;
  assign ctl_o.capture_front = (state_q == bdeq_pkg::ST_RD_REAR);
  assign ctl_o.capture_rear  = (state_q == bdeq_pkg::ST_DONE);

endmodule

// File: src/bdeq_checker.sv
module bdeq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               done_o,
  input logic                               ok_o,
  input logic signed [bdeq_pkg::DATA_W-1:0] front_value_o,
  input logic signed [bdeq_pkg::DATA_W-1:0] rear_value_o,
  input logic                               is_empty_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after an accepted command");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result beat without a command four cycles earlier");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while a command is in flight");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_empty_o |-> (front_value_o == -1) && (rear_value_o == -1) && (ok_o || !ok_o))
    else $error("empty deque did not report all ones at both ends");

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .ok_o         (ok_o),
  .front_value_o(front_value_o),
  .rear_value_o (rear_value_o),
  .is_empty_o   (is_empty_o)
);

// File: verif/tb_bounded_double_ended_queue.sv
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue;
  import bdeq_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int IDX_W = $clog2(RING_DEPTH);
  // After a drain, before a config write or the end of the test, let the block settle.
  // The settle wait covers any work still in flight.
  localparam int SETTLE_CYCLES = 4;
  // The watchdog fires after this many cycles in which no beat moves on either side.
  localparam int STALL_LIMIT = 1000;
  // Command codes that the block does not know. They must answer ok = 0 and leave the
  // state alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [CAP_W-1:0] CAP_MAX = '1;
  localparam logic [CAP_W-1:0] CAP_NONE = '0;

  // One expected result beat, laid out like the result ports.
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
    logic              is_empty;
    logic              is_full;
  } deq_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [CMD_W-1:0]          cmd_i;
  logic signed [DATA_W-1:0]  value_i;
  logic                      cfg_we_i;
  logic [CAP_W-1:0]          cfg_wdata_i;
  logic                      done_o;
  logic                      ok_o;
  logic signed [DATA_W-1:0]  front_value_o;
  logic signed [DATA_W-1:0]  rear_value_o;
  logic                      is_empty_o;
  logic                      is_full_o;

  bounded_double_ended_queue #(
    .DEPTH(RING_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow copy of the deque. Entries are only ever read inside the occupied window,
  // so the store needs no reset value.
  logic [DATA_W-1:0] ring_store [RING_DEPTH];
  logic [IDX_W-1:0]  head_idx;
  logic [CAP_W-1:0]  occupancy;
  logic [CAP_W-1:0]  capacity;

  deq_result_t pending_results [$];
  int          mismatch_count;
  int          idle_pct;
  int          quiet_cycles = 0;

  // Applies one command to the shadow deque and returns the result beat it must give.
  // A limit above the ring size saturates at the ring size; a limit of zero makes the
  // deque full and empty at once. A limit lowered below the count keeps the entries.
  function automatic deq_result_t deque_apply_cmd(input logic [CMD_W-1:0] op,
                                                  input logic [DATA_W-1:0] operand);
    deq_result_t res;
    int          lim;
    lim = (capacity > RING_DEPTH) ? RING_DEPTH : int'(capacity);
    res.ok = 1'b0;
    case (op)
      CMD_PUSH_FRONT: begin
        if (occupancy < lim) begin
          head_idx = (head_idx == 0) ? IDX_W'(RING_DEPTH - 1) : head_idx - 1'b1;
          ring_store[head_idx] = operand;
          occupancy++;
          res.ok = 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        if (occupancy < lim) begin
          ring_store[IDX_W'((head_idx + occupancy) % RING_DEPTH)] = operand;
          occupancy++;
          res.ok = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (occupancy != 0) begin
          head_idx = IDX_W'((head_idx + 1) % RING_DEPTH);
          occupancy--;
          res.ok = 1'b1;
        end
      end
      CMD_POP_REAR: begin
        if (occupancy != 0) begin
          occupancy--;
          res.ok = 1'b1;
        end
      end
      CMD_PEEK: begin
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    if (occupancy != 0) begin
      res.front_value = ring_store[head_idx];
      res.rear_value  = ring_store[IDX_W'((head_idx + occupancy - 1) % RING_DEPTH)];
    end else begin
      res.front_value = '1;
      res.rear_value  = '1;
    end
    res.is_empty = (occupancy == 0);
    res.is_full  = (occupancy >= lim);
    return res;
  endfunction

  // Sends one command beat. The sender may idle first; start_i stays high from one
  // beat to the next when it does not, so back-to-back commands are exercised.
  task automatic issue_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] operand);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= op;
    value_i <= operand;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(deque_apply_cmd(op, operand));
  endtask

  // Holds the sender off until every result beat has come back.
  task automatic wait_for_results();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The limit register is only written with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] limit);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = limit;
  endtask

  // Draws a command: pushes and pops at the given rates, the rest mostly peeks with
  // an occasional unknown code.
  function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      return $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      return $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
    end else if (roll < 96) begin
      return CMD_PEEK;
    end
    return CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
  endfunction

  // Every push and pop at the reset limit, including the ring wrap when pushing to the
  // front from head index zero, the extremes of the value field, peeks and unknown
  // codes on an empty and a filled deque, and refused pops.
  task automatic test_basic_commands();
    issue_cmd(CMD_PEEK, 32'h0);
    issue_cmd(CMD_POP_FRONT, 32'h0);
    issue_cmd(CMD_POP_REAR, 32'h0);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      issue_cmd(CMD_W'(c), $urandom);
    end
    issue_cmd(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    issue_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    issue_cmd(CMD_PUSH_REAR, 32'h0000_0000);
    issue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    issue_cmd(CMD_PEEK, $urandom);
    issue_cmd(CMD_UNUSED_LO, $urandom);
    issue_cmd(CMD_POP_REAR, $urandom);
    issue_cmd(CMD_POP_FRONT, $urandom);
    issue_cmd(CMD_POP_REAR, $urandom);
    issue_cmd(CMD_POP_FRONT, $urandom);
  endtask

  // Limit corner cases: a limit of one, a limit of zero (full and empty at once), and a
  // limit lowered below the current count, which keeps the entries but refuses pushes
  // until pops bring the count under the new limit.
  task automatic test_limit_corners();
    write_capacity(11'd1);
    issue_cmd(CMD_PUSH_REAR, $urandom);
    issue_cmd(CMD_PUSH_FRONT, $urandom);
    issue_cmd(CMD_POP_FRONT, $urandom);
    write_capacity(CAP_NONE);
    issue_cmd(CMD_PEEK, $urandom);
    issue_cmd(CMD_PUSH_FRONT, $urandom);
    issue_cmd(CMD_PUSH_REAR, $urandom);
    write_capacity(11'd8);
    repeat (4) issue_cmd(CMD_PUSH_REAR, $urandom);
    write_capacity(11'd2);
    issue_cmd(CMD_PEEK, $urandom);
    issue_cmd(CMD_PUSH_FRONT, $urandom);
    issue_cmd(CMD_POP_FRONT, $urandom);
    issue_cmd(CMD_POP_REAR, $urandom);
    issue_cmd(CMD_PUSH_FRONT, $urandom);
  endtask

  // Random traffic under a series of mostly small limits, where full and empty are hit often.
  // The first half of the settings runs with a light sender idle rate, the second half
  // with a heavy one. Halfway through each setting the sender waits for a full drain.
  task automatic test_random_small_limits();
    logic [CAP_W-1:0] limits [10];
    limits = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd7, 11'd16, CAP_NONE,
               11'($urandom_range(31, 1)), 11'($urandom_range(2047))};
    foreach (limits[i]) begin
      idle_pct = (i < 5) ? 12 : 78;
      write_capacity(limits[i]);
      for (int n = 0; n < 30; n++) begin
        if (n == 15) wait_for_results();
        issue_cmd(pick_cmd(45, 40), $urandom);
      end
    end
  endtask

  // Fills the whole ring with the limit at its largest code, which must saturate at the
  // ring size, then works around full. Then the limit is set to exactly the ring size.
  task automatic test_fill_to_depth();
    idle_pct = 0;
    write_capacity(CAP_MAX);
    while (occupancy < RING_DEPTH) begin
      issue_cmd(pick_cmd(95, 4), $urandom);
    end
    repeat (40) issue_cmd(pick_cmd(50, 30), $urandom);
    write_capacity(RING_DEPTH[CAP_W-1:0]);
    repeat (40) issue_cmd(pick_cmd(50, 30), $urandom);
  endtask

  // Compares one field of a result beat.
  function automatic void check_field(input string field_name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
      mismatch_count++;
    end
  endfunction

  // Every done_o beat is taken; it must match the oldest outstanding command.
  always @(posedge clk_i) begin
    deq_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with no command outstanding, expected none, actual ok=%b",
                 $time, ok_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, ok_o);
        check_field("front_value", want.front_value, front_value_o);
        check_field("rear_value", want.rear_value, rear_value_o);
        check_field("is_empty", want.is_empty, is_empty_o);
        check_field("is_full", want.is_full, is_full_o);
      end
    end
  end

  // Watchdog: counts cycles in which neither a command beat nor a result beat moves.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL bounded_double_ended_queue");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    cmd_i          <= CMD_PEEK;
    value_i        <= '0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    mismatch_count = 0;
    idle_pct       = 12;
    head_idx       = '0;
    occupancy      = '0;
    capacity       = CAP_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_limit_corners();
    test_random_small_limits();
    test_fill_to_depth();

    // Let the last results come back, then watch a little longer for stray beats.
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS bounded_double_ended_queue");
    end else begin
      $display("FAIL bounded_double_ended_queue");
    end
    $finish;
  end

endmodule

// File: files.f
src/bdeq_pkg.sv
src/bdeq_ram.sv
src/bdeq_ctrl.sv
src/bounded_double_ended_queue.sv
src/bdeq_checker.sv
verif/tb_bounded_double_ended_queue.sv
